// ===== rtl/sifu_pkg.sv =====
package sifu_pkg;

  typedef enum logic [1:0] {
    CT_GROUNDED = 2'd0,
    CT_FLOATING = 2'd1,
    CT_LAND     = 2'd2,
    CT_OCEAN    = 2'd3
  } cell_type_t;

  localparam int unsigned VelW   = 32;
  localparam int unsigned ThickW = 31;
  localparam int unsigned FluxW  = 64;
  localparam int unsigned FracW  = 16;

  typedef logic signed [VelW-1:0]  vel_t;
  typedef logic [ThickW-1:0]       thick_t;
  typedef logic signed [FluxW-1:0] flux_t;

  // limited velocity and diffusive gate handed to the flux datapath
  typedef struct packed {
    vel_t velocity;
    logic pass_diff;
  } vel_ctl_t;

  function automatic logic is_icy(cell_type_t t);
    return (t == CT_GROUNDED) || (t == CT_FLOATING);
  endfunction

  // exact 33-bit sum, arithmetic shift right by one, always fits 32 bits
  function automatic vel_t mean2(vel_t a, vel_t b);
    logic signed [VelW:0] s;
    logic signed [VelW:0] h;
    s = {a[VelW-1], a} + {b[VelW-1], b};
    h = s >>> 1;
    return h[VelW-1:0];
  endfunction

endpackage

// ===== rtl/sifu_item_if.sv =====
interface sifu_item_if;
  logic                valid;
  logic                ready;
  logic [1:0]          cell_type_here;
  logic [1:0]          cell_type_neighbor;
  logic                bc_here;
  logic                bc_neighbor;
  sifu_pkg::vel_t      velocity_here;
  sifu_pkg::vel_t      velocity_neighbor;
  sifu_pkg::vel_t      bc_velocity_here;
  sifu_pkg::vel_t      bc_velocity_neighbor;
  sifu_pkg::thick_t    thickness_here;
  sifu_pkg::thick_t    thickness_neighbor;
  sifu_pkg::vel_t      diffusive_flux_in;

  modport source (
    output valid, cell_type_here, cell_type_neighbor, bc_here, bc_neighbor,
           velocity_here, velocity_neighbor, bc_velocity_here, bc_velocity_neighbor,
           thickness_here, thickness_neighbor, diffusive_flux_in,
    input  ready
  );

  modport sink (
    input  valid, cell_type_here, cell_type_neighbor, bc_here, bc_neighbor,
           velocity_here, velocity_neighbor, bc_velocity_here, bc_velocity_neighbor,
           thickness_here, thickness_neighbor, diffusive_flux_in,
    output ready
  );
endinterface

// ===== rtl/sifu_result_if.sv =====
interface sifu_result_if;
  logic             valid;
  logic             ready;
  sifu_pkg::vel_t   interface_velocity;
  sifu_pkg::flux_t  interface_flux;

  modport source (
    output valid, interface_velocity, interface_flux,
    input  ready
  );

  modport sink (
    input  valid, interface_velocity, interface_flux,
    output ready
  );
endinterface

// ===== rtl/sifu_velocity.sv =====
module sifu_velocity (
  input  sifu_pkg::cell_type_t type_here,
  input  sifu_pkg::cell_type_t type_neighbor,
  input  logic                 bc_here,
  input  logic                 bc_neighbor,
  input  sifu_pkg::vel_t       velocity_here,
  input  sifu_pkg::vel_t       velocity_neighbor,
  input  sifu_pkg::vel_t       bc_velocity_here,
  input  sifu_pkg::vel_t       bc_velocity_neighbor,
  output sifu_pkg::vel_ctl_t   ctl
);

  logic           icy_here;
  logic           icy_neighbor;
  logic           zero_vel;
  sifu_pkg::vel_t v_cell;
  sifu_pkg::vel_t v_bc;

  assign icy_here     = sifu_pkg::is_icy(type_here);
  assign icy_neighbor = sifu_pkg::is_icy(type_neighbor);

  // velocity from the cell values
  always_comb begin
    if (icy_here && icy_neighbor) begin
      v_cell = sifu_pkg::mean2(velocity_here, velocity_neighbor);
    end else if (icy_here) begin
      v_cell = velocity_here;
    end else if (icy_neighbor) begin
      v_cell = velocity_neighbor;
    end else begin
      v_cell = '0;
    end
  end

  // boundary override
  always_comb begin
    if (bc_here && bc_neighbor) begin
      v_bc = sifu_pkg::mean2(bc_velocity_here, bc_velocity_neighbor);
    end else if (bc_here) begin
      v_bc = bc_velocity_here;
    end else if (bc_neighbor) begin
      v_bc = bc_velocity_neighbor;
    end else begin
      v_bc = v_cell;
    end
  end

  // floating next to land, or two ice-free cells, carry no advection
  assign zero_vel =
      (type_here == sifu_pkg::CT_FLOATING && type_neighbor == sifu_pkg::CT_LAND) ||
      (type_here == sifu_pkg::CT_LAND && type_neighbor == sifu_pkg::CT_FLOATING) ||
      (!icy_here && !icy_neighbor);

  assign ctl.velocity  = zero_vel ? '0 : v_bc;
  assign ctl.pass_diff = (type_here == sifu_pkg::CT_GROUNDED) ||
                         (type_neighbor == sifu_pkg::CT_GROUNDED);

endmodule

// ===== rtl/staggered_interface_flux_upwind.sv =====
// first-order upwind flux through one cell interface of a staggered grid
//
// channels: item (sink) carries one interface per transfer: cell types,
// boundary flags and velocities of both sides, both thicknesses and the
// diffusive flux. result (source) returns the limited interface velocity
// (Q16.16) and the total flux (Q32.32), exactly one result per item, in order.
//
// timing: an item is held in the input register; velocity selection,
// one 32x32 multiply and the 64-bit add run between that register and the
// result register, so each result is registered from the item held in the
// input register. throughput is one item per cycle while the result side
// keeps taking results, set by the single multiplier path.
//
// stalls: the input register takes a new item whenever it is empty or its
// item moves into the result register, which happens whenever the result
// register is empty or its result is being taken. a held result thus
// still leaves room for one more item before item.ready falls.
//
// reset (rst, synchronous, active high) empties both registers; payload
// registers are not cleared. the block holds no other state.
module staggered_interface_flux_upwind (
  input logic         clk,
  input logic         rst,
  sifu_item_if.sink   item,
  sifu_result_if.source result
);

  // input register
  logic                 a_valid;
  sifu_pkg::cell_type_t a_type_here;
  sifu_pkg::cell_type_t a_type_neighbor;
  logic                 a_bc_here;
  logic                 a_bc_neighbor;
  sifu_pkg::vel_t       a_vel_here;
  sifu_pkg::vel_t       a_vel_neighbor;
  sifu_pkg::vel_t       a_bc_vel_here;
  sifu_pkg::vel_t       a_bc_vel_neighbor;
  sifu_pkg::thick_t     a_thick_here;
  sifu_pkg::thick_t     a_thick_neighbor;
  sifu_pkg::vel_t       a_diff;

  // result register
  logic                 r_valid;
  sifu_pkg::vel_t       r_velocity;
  sifu_pkg::flux_t      r_flux;

  logic                 out_adv;
  logic                 in_take;

  sifu_pkg::vel_ctl_t   ctl;
  sifu_pkg::thick_t     upwind_thick;
  logic signed [sifu_pkg::VelW-1:0]  thick_s;
  sifu_pkg::flux_t      adv_flux;
  sifu_pkg::flux_t      diff_flux;
  sifu_pkg::flux_t      flux_next;

  // result register moves when empty or being drained
  assign out_adv     = !r_valid || result.ready;
  assign item.ready  = !a_valid || out_adv;
  assign in_take     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (out_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_type_here       <= sifu_pkg::cell_type_t'(item.cell_type_here);
      a_type_neighbor   <= sifu_pkg::cell_type_t'(item.cell_type_neighbor);
      a_bc_here         <= item.bc_here;
      a_bc_neighbor     <= item.bc_neighbor;
      a_vel_here        <= item.velocity_here;
      a_vel_neighbor    <= item.velocity_neighbor;
      a_bc_vel_here     <= item.bc_velocity_here;
      a_bc_vel_neighbor <= item.bc_velocity_neighbor;
      a_thick_here      <= item.thickness_here;
      a_thick_neighbor  <= item.thickness_neighbor;
      a_diff            <= item.diffusive_flux_in;
    end
  end

  // velocity choice, boundary override and cell-type limiting
  sifu_velocity u_velocity (
    .type_here            (a_type_here),
    .type_neighbor        (a_type_neighbor),
    .bc_here              (a_bc_here),
    .bc_neighbor          (a_bc_neighbor),
    .velocity_here        (a_vel_here),
    .velocity_neighbor    (a_vel_neighbor),
    .bc_velocity_here     (a_bc_vel_here),
    .bc_velocity_neighbor (a_bc_vel_neighbor),
    .ctl                  (ctl)
  );

  // upwind side: here for strictly positive velocity, else the neighbour
  assign upwind_thick = (!ctl.velocity[sifu_pkg::VelW-1] && (ctl.velocity != '0)) ?
                        a_thick_here : a_thick_neighbor;
  assign thick_s      = $signed({1'b0, upwind_thick});
  assign adv_flux     = sifu_pkg::FluxW'(ctl.velocity) * sifu_pkg::FluxW'(thick_s);

  // diffusive flux moved to Q32.32, gated by grounded ice on either side
  assign diff_flux = ctl.pass_diff ?
                     (sifu_pkg::FluxW'(a_diff) <<< sifu_pkg::FracW) : '0;
  assign flux_next = diff_flux + adv_flux;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (out_adv) begin
      r_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && a_valid) begin
      r_velocity <= ctl.velocity;
      r_flux     <= flux_next;
    end
  end

  assign result.valid              = r_valid;
  assign result.interface_velocity = r_velocity;
  assign result.interface_flux     = r_flux;

endmodule
